@@ rtl/jpu_pkg.sv @@
// Shared widths, constants and word types for the particle jet update pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package jpu_pkg;

   localparam int POS_W   = 32;
   localparam int LIFE_W  = 24;
   localparam int SEED_W  = 16;
   localparam int COL_W   = 16;
   localparam int T_W     = 17;
   localparam int NUM_W   = LIFE_W + 17;
   localparam int DEPTH   = 21;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_AT_BIRTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_FLOOR_BASE = 1'd1;

   localparam logic [T_W-1:0] ONE_T      = 17'd65536;
   localparam logic [T_W-1:0] BREAK_LOW  = 17'd13107;
   localparam logic [T_W-1:0] BREAK_HIGH = 17'd32768;

   localparam int DAMP_Q16  = 60293;
   localparam int SHADE_Q16 = 9830;
   localparam int FLOOR_Q16 = 19661;
   localparam int DIV3_MUL  = 174763;

   localparam int C_ONE = 65535;
   localparam int C_095 = 62258;
   localparam int C_070 = 45875;
   localparam int C_040 = 26214;
   localparam int C_020 = 13107;
   localparam int C_010 = 6554;
   localparam int C_090 = 58982;

   typedef logic signed [POS_W-1:0] coord_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      coord_type vel_x;
      coord_type vel_y;
      coord_type vel_z;
   } motion_type;

   typedef struct packed {
      logic              zero_life;
      logic              no_age;
      logic [SEED_W-1:0] seed;
   } side_type;

endpackage
`default_nettype wire

@@ rtl/jpu_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on jpu_pkg for widths.
`default_nettype none
module jpu_div (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [jpu_pkg::NUM_W-1:0]  numer,
   input  wire logic [jpu_pkg::LIFE_W-1:0] denom,
   output logic      [jpu_pkg::T_W-1:0]    quot
);
   import jpu_pkg::*;

   logic [LIFE_W-1:0] rem_src [0:T_W-1];
   logic [T_W-1:0]    low_src [0:T_W-1];
   logic [LIFE_W-1:0] den_src [0:T_W-1];
   logic [T_W-1:0]    q_src   [0:T_W-1];

   logic [LIFE_W-1:0] rem_ff [0:T_W-1];
   logic [T_W-1:0]    low_ff [0:T_W-1];
   logic [LIFE_W-1:0] den_ff [0:T_W-1];
   logic [T_W-1:0]    q_ff   [0:T_W-1];

   for (genvar k = 0; k < T_W; k++) begin : g_stage
      logic [LIFE_W:0]   trial;
      logic [LIFE_W:0]   diff;
      logic              take;
      logic [LIFE_W-1:0] rem_in;
      logic [T_W-1:0]    q_in;

      if (k == 0) begin : g_first
         assign rem_src[k] = numer[NUM_W-1:T_W];
         assign low_src[k] = numer[T_W-1:0];
         assign den_src[k] = denom;
         assign q_src[k]   = '0;
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign low_src[k] = low_ff[k-1];
         assign den_src[k] = den_ff[k-1];
         assign q_src[k]   = q_ff[k-1];
      end

      always_comb begin
         trial  = {rem_src[k], low_src[k][T_W-1-k]};
         diff   = trial - {1'b0, den_src[k]};
         take   = (trial >= {1'b0, den_src[k]});
         rem_in = take ? diff[LIFE_W-1:0] : trial[LIFE_W-1:0];
         q_in   = q_src[k];
         q_in[T_W-1-k] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_src[k];
            den_ff[k] <= den_src[k];
            q_ff[k]   <= q_in;
         end
      end
   end

   assign quot = q_ff[T_W-1];

endmodule
`default_nettype wire

@@ rtl/jpu_motion.sv @@
// Position advance and velocity damping, two register stages.
// Depends on jpu_pkg for the coordinate and motion word types.
`default_nettype none
module jpu_motion #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire jpu_pkg::motion_type        cur,
   input  wire logic [jpu_pkg::LIFE_W-1:0] dt,
   output jpu_pkg::motion_type             nxt
);
   import jpu_pkg::*;

   localparam int PD_W = POS_W + LIFE_W + 1;
   localparam int PV_W = POS_W + 17;
   localparam int SUM_W = PD_W + 1;

   logic signed [PD_W-1:0] pd_ff [0:2];
   logic signed [PV_W-1:0] pv_ff [0:2];
   coord_type              p_ff  [0:2];
   motion_type             nxt_ff;

   coord_type cur_p [0:2];
   coord_type cur_v [0:2];
   coord_type new_p [0:2];
   coord_type new_v [0:2];

   assign cur_p[0] = cur.pos_x;
   assign cur_p[1] = cur.pos_y;
   assign cur_p[2] = cur.pos_z;
   assign cur_v[0] = cur.vel_x;
   assign cur_v[1] = cur.vel_y;
   assign cur_v[2] = cur.vel_z;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic signed [PD_W-1:0]  d_rnd;
      logic signed [SUM_W-1:0] sum;
      logic signed [PV_W-1:0]  v_rnd;

      always_comb begin
         d_rnd = (pd_ff[i] + (PD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         sum   = SUM_W'(p_ff[i]) + SUM_W'(d_rnd);
         if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
            new_p[i] = 32'sh7FFF_FFFF;
         end else if (sum < -SUM_W'(33'sh0_8000_0000)) begin
            new_p[i] = 32'sh8000_0000;
         end else begin
            new_p[i] = sum[POS_W-1:0];
         end
         v_rnd    = (pv_ff[i] + PV_W'(32768)) >>> 16;
         new_v[i] = v_rnd[POS_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pd_ff[i] <= PD_W'(cur_v[i]) * PD_W'($signed({1'b0, dt}));
            pv_ff[i] <= PV_W'(cur_v[i]) * PV_W'(DAMP_Q16);
            p_ff[i]  <= cur_p[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff.pos_x <= new_p[0];
         nxt_ff.pos_y <= new_p[1];
         nxt_ff.pos_z <= new_p[2];
         nxt_ff.vel_x <= new_v[0];
         nxt_ff.vel_y <= new_v[1];
         nxt_ff.vel_z <= new_v[2];
      end
   end

   assign nxt = nxt_ff;

endmodule
`default_nettype wire

@@ rtl/jpu_shade.sv @@
// Colour ramp, alpha and size from the age fraction, three register stages.
// Depends on jpu_pkg for ramp constants and widths.
`default_nettype none
module jpu_shade (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [jpu_pkg::T_W-1:0]    age,
   input  wire logic [jpu_pkg::SEED_W-1:0] seed,
   input  wire logic [jpu_pkg::COL_W-1:0]  size_birth,
   input  wire logic [jpu_pkg::COL_W-1:0]  size_floor,
   output logic      [jpu_pkg::COL_W-1:0]  red,
   output logic      [jpu_pkg::COL_W-1:0]  green,
   output logic      [jpu_pkg::COL_W-1:0]  blue,
   output logic      [jpu_pkg::COL_W-1:0]  alpha,
   output logic      [jpu_pkg::COL_W-1:0]  size
);
   import jpu_pkg::*;

   typedef struct packed {
      logic signed [17:0] base;
      logic signed [17:0] delta;
   } ramp_type;

   // stage A
   logic [20:0]        x10;
   logic signed [21:0] xs;
   logic [17:0]        xp1;
   logic [35:0]        q3;
   logic [29:0]        sh_prod;
   logic [13:0]        shade;
   logic [31:0]        fin_prod;
   logic [15:0]        fin;
   logic [T_W-1:0]     s_in;
   ramp_type           ramp_in [0:3];

   ramp_type           ramp_a_ff [0:3];
   logic [T_W-1:0]     s_a_ff;
   logic [T_W-1:0]     t_a_ff;
   logic [33:0]        tt_a_ff;

   // stage B
   logic signed [35:0] prod_b_ff [0:3];
   logic signed [17:0] base_b_ff [0:3];
   logic [COL_W-1:0]   alpha_b_ff;
   logic [17:0]        tt_rnd;
   logic [17:0]        al;

   // stage C
   logic [COL_W-1:0]   res_ff [0:3];
   logic [COL_W-1:0]   alpha_ff;

   always_comb begin
      x10      = 21'({age, 3'b000}) + 21'({age, 1'b0});
      xs       = $signed({1'b0, x10}) - 22'sd131072;
      xp1      = xs[17:0] + 18'd1;
      q3       = 36'(xp1) * 36'(DIV3_MUL);
      sh_prod  = 30'(seed) * 30'(SHADE_Q16);
      shade    = 14'((sh_prod + 30'd32768) >> 16);
      fin_prod = 32'(size_floor) * 32'(FLOOR_Q16);
      fin      = 16'((fin_prod + 32'd32768) >> 16);

      if (age < BREAK_LOW) begin
         s_in             = 17'(age * 17'd5);
         ramp_in[0].base  = 18'(C_ONE);
         ramp_in[0].delta = '0;
         ramp_in[1].base  = 18'(C_095);
         ramp_in[1].delta = 18'(C_040 - C_095);
         ramp_in[2].base  = 18'(C_070);
         ramp_in[2].delta = 18'(C_010 - C_070);
      end else if (age < BREAK_HIGH) begin
         s_in             = xs[21] ? '0 : q3[35:19];
         ramp_in[0].base  = 18'(C_ONE);
         ramp_in[0].delta = '0;
         ramp_in[1].base  = 18'(C_040);
         ramp_in[1].delta = 18'(C_020 - C_040);
         ramp_in[2].base  = 18'(C_010);
         ramp_in[2].delta = 18'(C_020 - C_010);
      end else begin
         s_in             = 17'({age - BREAK_HIGH, 1'b0});
         ramp_in[0].base  = 18'(C_ONE);
         ramp_in[0].delta = 18'(C_010 - C_ONE) + 18'(shade);
         ramp_in[1].base  = 18'(C_020);
         ramp_in[1].delta = 18'(shade);
         ramp_in[2].base  = 18'(C_020);
         ramp_in[2].delta = 18'(C_090 - C_020);
      end
      ramp_in[3].base  = 18'(size_birth);
      ramp_in[3].delta = 18'(fin) - 18'(size_birth);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ramp_a_ff <= ramp_in;
         s_a_ff    <= s_in;
         t_a_ff    <= age;
         tt_a_ff   <= 34'(age) * 34'(age);
      end
   end

   always_comb begin
      tt_rnd = 18'((tt_a_ff + 34'd32768) >> 16);
      al     = 18'(ONE_T) - tt_rnd;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_b_ff[i] <= 36'(ramp_a_ff[i].delta) * 36'($signed({1'b0, s_a_ff}));
            base_b_ff[i] <= ramp_a_ff[i].base;
         end
         prod_b_ff[3] <= 36'(ramp_a_ff[3].delta) * 36'($signed({1'b0, t_a_ff}));
         base_b_ff[3] <= ramp_a_ff[3].base;
         alpha_b_ff   <= (al > 18'd65535) ? 16'hFFFF : al[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            res_ff[i] <= COL_W'(base_b_ff[i]
                         + 18'((prod_b_ff[i] + 36'sd32768) >>> 16));
         end
         alpha_ff <= alpha_b_ff;
      end
   end

   assign red   = res_ff[0];
   assign green = res_ff[1];
   assign blue  = res_ff[2];
   assign size  = res_ff[3];
   assign alpha = alpha_ff;

endmodule
`default_nettype wire

@@ rtl/particle_jet_update_step.sv @@
// Particle jet update step: top level, uses jpu_pkg, jpu_div, jpu_motion, jpu_shade.
// A response word follows its accepted request word through the input register,
// the 17-stage age divider and three ramp stages.
// Throughput: one word per cycle; the whole pipeline holds while a valid response word is stalled.
// Reset clears valid bits and loads the size registers (4096, 1536); no clearing pass.
`default_nettype none
module particle_jet_update_step #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [31:0]            req_pos_x,
   input  wire logic signed [31:0]            req_pos_y,
   input  wire logic signed [31:0]            req_pos_z,
   input  wire logic signed [31:0]            req_vel_x,
   input  wire logic signed [31:0]            req_vel_y,
   input  wire logic signed [31:0]            req_vel_z,
   input  wire logic [23:0]                   req_life_left,
   input  wire logic [23:0]                   req_life_total,
   input  wire logic [15:0]                   req_shade_seed,
   input  wire logic [23:0]                   req_time_step,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [31:0]                 rsp_new_pos_x,
   output logic signed [31:0]                 rsp_new_pos_y,
   output logic signed [31:0]                 rsp_new_pos_z,
   output logic signed [31:0]                 rsp_new_vel_x,
   output logic signed [31:0]                 rsp_new_vel_y,
   output logic signed [31:0]                 rsp_new_vel_z,
   output logic [15:0]                        rsp_color_red,
   output logic [15:0]                        rsp_color_green,
   output logic [15:0]                        rsp_color_blue,
   output logic [15:0]                        rsp_color_alpha,
   output logic [15:0]                        rsp_size_out,
   input  wire logic                          csr_write,
   input  wire logic [jpu_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_wdata
);
   import jpu_pkg::*;

   logic              en;
   logic [DEPTH-1:0]  vld_ff;
   logic [COL_W-1:0]  birth_ff;
   logic [COL_W-1:0]  floor_ff;

   motion_type        mot_in_ff;
   logic [LIFE_W-1:0] left_ff;
   logic [LIFE_W-1:0] total_ff;
   logic [SEED_W-1:0] seed_ff;
   logic [LIFE_W-1:0] dt_ff;

   logic [LIFE_W-1:0] diff;
   logic [NUM_W-1:0]  numer;
   logic [T_W-1:0]    quot;
   logic [T_W-1:0]    age;
   side_type          side_in;
   side_type          side_ff [0:T_W-1];
   motion_type        mot_out;
   motion_type        mot_d_ff [0:DEPTH-4];

   assign en        = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         birth_ff <= 16'd4096;
         floor_ff <= 16'd1536;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
         end
         if (csr_write) begin
            case (csr_index)
               CSR_SIZE_AT_BIRTH:   birth_ff <= csr_wdata;
               CSR_SIZE_FLOOR_BASE: floor_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mot_in_ff.pos_x <= req_pos_x;
         mot_in_ff.pos_y <= req_pos_y;
         mot_in_ff.pos_z <= req_pos_z;
         mot_in_ff.vel_x <= req_vel_x;
         mot_in_ff.vel_y <= req_vel_y;
         mot_in_ff.vel_z <= req_vel_z;
         left_ff         <= req_life_left;
         total_ff        <= req_life_total;
         seed_ff         <= req_shade_seed;
         dt_ff           <= req_time_step;
      end
   end

   always_comb begin
      diff              = total_ff - left_ff;
      numer             = {diff, 16'h0000} + NUM_W'(total_ff >> 1);
      side_in.zero_life = (total_ff == '0);
      side_in.no_age    = (left_ff >= total_ff);
      side_in.seed      = seed_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < T_W; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         mot_d_ff[0] <= mot_out;
         for (int i = 1; i < DEPTH - 3; i++) begin
            mot_d_ff[i] <= mot_d_ff[i-1];
         end
      end
   end

   jpu_div u_div (
      .clock (clock),
      .en    (en),
      .numer (numer),
      .denom (total_ff),
      .quot  (quot)
   );

   always_comb begin
      if (side_ff[T_W-1].zero_life) begin
         age = ONE_T;
      end else if (side_ff[T_W-1].no_age) begin
         age = '0;
      end else begin
         age = quot;
      end
   end

   jpu_motion #(
      .FRAC_BITS (FRAC_BITS)
   ) u_motion (
      .clock (clock),
      .en    (en),
      .cur   (mot_in_ff),
      .dt    (dt_ff),
      .nxt   (mot_out)
   );

   jpu_shade u_shade (
      .clock      (clock),
      .en         (en),
      .age        (age),
      .seed       (side_ff[T_W-1].seed),
      .size_birth (birth_ff),
      .size_floor (floor_ff),
      .red        (rsp_color_red),
      .green      (rsp_color_green),
      .blue       (rsp_color_blue),
      .alpha      (rsp_color_alpha),
      .size       (rsp_size_out)
   );

   assign rsp_new_pos_x = mot_d_ff[DEPTH-4].pos_x;
   assign rsp_new_pos_y = mot_d_ff[DEPTH-4].pos_y;
   assign rsp_new_pos_z = mot_d_ff[DEPTH-4].pos_z;
   assign rsp_new_vel_x = mot_d_ff[DEPTH-4].vel_x;
   assign rsp_new_vel_y = mot_d_ff[DEPTH-4].vel_y;
   assign rsp_new_vel_z = mot_d_ff[DEPTH-4].vel_z;

   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow a blocked response");

   a_age_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[T_W] |-> age <= ONE_T)
      else $error("age fraction above one");

   a_zero_life_full_age: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[T_W] && side_ff[T_W-1].zero_life) |-> age == ONE_T)
      else $error("zero total life did not give full age");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[T_W] && !en) |=> $stable(age))
      else $error("age stage moved while the pipeline held");

endmodule
`default_nettype wire

@@ test/tb_particle_jet_update_step.sv @@
// Self-checking bench for the particle jet update step: random and directed particles,
// each response compared with an in-bench fixed-point prediction. Uses jpu_pkg.
`timescale 1ns / 100ps
module tb_particle_jet_update_step;
   import jpu_pkg::*;

   typedef struct packed {
      logic signed [31:0] px, py, pz, vx, vy, vz;
      logic [23:0]        left, total;
      logic [15:0]        seed;
      logic [23:0]        dt;
   } particle_type;

   typedef struct packed {
      logic signed [31:0] px, py, pz, vx, vy, vz;
      logic [15:0]        red, green, blue, alpha, size;
   } update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   particle_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   update_type rsp_word;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SIZE_AT_BIRTH;
   logic [15:0] csr_wdata = '0;

   logic [15:0] birth_size = 16'd4096;
   logic [15:0] floor_base = 16'd1536;
   update_type pending_updates[$];
   int mismatches = 0;
   int stall_mode = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   particle_jet_update_step u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_word.px), .req_pos_y(req_word.py), .req_pos_z(req_word.pz),
      .req_vel_x(req_word.vx), .req_vel_y(req_word.vy), .req_vel_z(req_word.vz),
      .req_life_left(req_word.left), .req_life_total(req_word.total),
      .req_shade_seed(req_word.seed), .req_time_step(req_word.dt),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_new_pos_x(rsp_word.px), .rsp_new_pos_y(rsp_word.py),
      .rsp_new_pos_z(rsp_word.pz), .rsp_new_vel_x(rsp_word.vx),
      .rsp_new_vel_y(rsp_word.vy), .rsp_new_vel_z(rsp_word.vz),
      .rsp_color_red(rsp_word.red), .rsp_color_green(rsp_word.green),
      .rsp_color_blue(rsp_word.blue), .rsp_color_alpha(rsp_word.alpha),
      .rsp_size_out(rsp_word.size),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic longint rnd_shr(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint blend(longint a, longint b, longint s);
      return a + rnd_shr((b - a) * s, 16);
   endfunction

   function automatic update_type advance_particle(particle_type p);
      update_type u;
      longint pos[3], vel[3], t, s, shift, r, g, b, alpha, fin;
      pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
      vel[0] = p.vx; vel[1] = p.vy; vel[2] = p.vz;
      u.px = clamp32(pos[0] + rnd_shr(vel[0] * longint'(p.dt), 16));
      u.py = clamp32(pos[1] + rnd_shr(vel[1] * longint'(p.dt), 16));
      u.pz = clamp32(pos[2] + rnd_shr(vel[2] * longint'(p.dt), 16));
      u.vx = clamp32(rnd_shr(vel[0] * DAMP_Q16, 16));
      u.vy = clamp32(rnd_shr(vel[1] * DAMP_Q16, 16));
      u.vz = clamp32(rnd_shr(vel[2] * DAMP_Q16, 16));
      if (p.total == 0) t = 65536;
      else if (p.left >= p.total) t = 0;
      else t = ((longint'(p.total - p.left) <<< 16) + (p.total >> 1)) / p.total;
      shift = rnd_shr(longint'(p.seed) * SHADE_Q16, 16);
      if (t < 13107) begin
         s = 5 * t;
         r = C_ONE;
         g = blend(C_095, C_040, s);
         b = blend(C_070, C_010, s);
      end else if (t < 32768) begin
         s = 10 * t - 131072;
         s = (s < 0) ? 0 : (s + 1) / 3;
         r = C_ONE;
         g = blend(C_040, C_020, s);
         b = blend(C_010, C_020, s);
      end else begin
         s = 2 * (t - 32768);
         r = blend(C_ONE, C_010 + shift, s);
         g = blend(C_020, C_020 + shift, s);
         b = blend(C_020, C_090, s);
      end
      alpha = 65536 - rnd_shr(t * t, 16);
      if (alpha > 65535) alpha = 65535;
      if (alpha < 0) alpha = 0;
      fin = rnd_shr(longint'(floor_base) * FLOOR_Q16, 16);
      u.red = r[15:0];
      u.green = g[15:0];
      u.blue = b[15:0];
      u.alpha = alpha[15:0];
      u.size = 16'(blend(birth_size, fin, t));
      return u;
   endfunction

   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      update_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_word);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_word !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h got %h", want, rsp_word);
            end
         end
      end
   end

   task automatic send_particle(particle_type p);
      req_valid <= 1'b1;
      req_word <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_updates.push_back(advance_particle(p));
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_SIZE_AT_BIRTH) birth_size = val;
      else floor_base = val;
   endtask

   function automatic particle_type rand_particle();
      particle_type p;
      p.px = $urandom;
      p.py = $urandom;
      p.pz = $urandom;
      p.vx = $urandom;
      p.vy = $urandom;
      p.vz = $urandom;
      p.left = 24'($urandom);
      p.total = 24'($urandom);
      p.seed = 16'($urandom);
      p.dt = 24'($urandom);
      case ($urandom_range(0, 5))
         0: p.total = 0;
         1: p.left = 24'(p.total + $urandom_range(0, 3));
         2: p.left = 24'(p.total - $urandom_range(1, 3));
         3: begin
            p.total = 24'($urandom_range(1, 5000));
            p.left = 24'($urandom_range(0, p.total));
         end
         default: p.left = 24'($urandom_range(0, p.total));
      endcase
      if ($urandom_range(0, 2) == 0) begin
         p.vx = $signed(p.vx) >>> 12;
         p.vy = $signed(p.vy) >>> 12;
         p.vz = $signed(p.vz) >>> 12;
         p.dt = p.dt >> 10;
      end
      return p;
   endfunction

   task automatic test_directed();
      particle_type p;
      stall_mode = 0;
      p = '0;
      send_particle(p);
      p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
            24'h0, 24'h1, 16'hFFFF, 24'hFFFFFF};
      send_particle(p);
      p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001,
            32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1,
            24'hFFFFFF, 24'hFFFFFF, 16'h0, 24'hFFFFFF};
      send_particle(p);
      p.total = 24'd100;
      for (int i = 0; i <= 10; i++) begin
         p.left = 24'(100 - i * 10);
         p.seed = 16'(i * 6553);
         p.vx = -(i * 3);
         p.dt = 24'(i * 32768);
         send_particle(p);
      end
      p.total = 24'd65536;
      p.left = 24'(65536 - 13107); send_particle(p);
      p.left = 24'(65536 - 13106); send_particle(p);
      p.left = 24'd32768; send_particle(p);
      p.left = 24'd32769; send_particle(p);
      p.left = 24'd70000; send_particle(p);
   endtask

   task automatic test_random(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && count > 0; i++, count--)
            send_particle(rand_particle());
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic test_sizes();
      write_reg(CSR_SIZE_AT_BIRTH, 16'hFFFF);
      write_reg(CSR_SIZE_FLOOR_BASE, 16'h0);
      test_random(300);
      write_reg(CSR_SIZE_AT_BIRTH, 16'h0);
      write_reg(CSR_SIZE_FLOOR_BASE, 16'hFFFF);
      test_random(300);
      write_reg(CSR_SIZE_AT_BIRTH, 16'($urandom));
      write_reg(CSR_SIZE_FLOOR_BASE, 16'($urandom));
      test_random(300);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int m = 0; m < 4; m++) begin
         stall_mode = m;
         test_random(220);
      end
      stall_mode = 1;
      test_sizes();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);
      if (mismatches == 0 && pending_updates.size() == 0)
         $display("PASS particle_jet_update_step");
      else
         $display("FAIL particle_jet_update_step");
      $finish;
   end

   initial begin
      #400000;
      $display("FAIL particle_jet_update_step");
      $finish;
   end

endmodule

@@ particle_jet_update_step.f @@
rtl/jpu_pkg.sv
rtl/jpu_div.sv
rtl/jpu_motion.sv
rtl/jpu_shade.sv
rtl/particle_jet_update_step.sv
test/tb_particle_jet_update_step.sv
